// ===== rtl/u8d_pkg.sv =====
package u8d_pkg;

	// Register map (byte addresses, one 32-bit word each); decode uses paddr[2]
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic REG_BYTE_LIMIT = 1'b0;
	localparam logic REG_CHAR_LIMIT = 1'b1;

	localparam int unsigned BYTE_LIMIT_W = 15;
	localparam int unsigned CHAR_LIMIT_W = 13;
	localparam logic [BYTE_LIMIT_W-1:0] BYTE_LIMIT_RST = 15'd32000;
	localparam logic [CHAR_LIMIT_W-1:0] CHAR_LIMIT_RST = 13'd8000;

	localparam int unsigned SCALAR_W = 21;
	localparam int unsigned OUT_OFF_W = 15;
	localparam logic [SCALAR_W-1:0] SCALAR_MAX = 21'h10ffff;
	localparam logic [SCALAR_W-1:0] SURR_LO = 21'h00d800;
	localparam logic [SCALAR_W-1:0] SURR_HI = 21'h00dfff;

	// Minimum scalar class of the sequence being built (overlong check)
	typedef enum logic [1:0] {
		MIN_NONE = 2'd0,
		MIN_2B   = 2'd1,
		MIN_3B   = 2'd2,
		MIN_4B   = 2'd3
	} min_class_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_LEAD      = 3'd1,
		ERR_TRUNC     = 3'd2,
		ERR_CONT      = 3'd3,
		ERR_SCALAR    = 3'd4,
		ERR_CONTROL   = 3'd5,
		ERR_BYTES     = 3'd6,
		ERR_CHARS     = 3'd7
	} err_code_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       text_end;
	} in_item_t;

	typedef struct packed {
		logic [SCALAR_W-1:0]  scalar;
		logic [OUT_OFF_W-1:0] start_offset;
		logic                 is_space;
		err_code_t            error_code;
		logic                 end_of_run;
	} out_item_t;

	function automatic logic [SCALAR_W-1:0] min_scalar(input min_class_t cls);
		logic [SCALAR_W-1:0] m;
		case (cls)
			MIN_NONE: m = 21'h000000;
			MIN_2B:   m = 21'h000080;
			MIN_3B:   m = 21'h000800;
			MIN_4B:   m = 21'h010000;
			default:  m = 21'h000000;
		endcase
		return m;
	endfunction

	// Unicode White_Space set, plus U+001C..U+001F
	function automatic logic is_ws(input logic [SCALAR_W-1:0] v);
		return (v >= 21'h09 && v <= 21'h0d) || (v >= 21'h1c && v <= 21'h20) ||
			v == 21'h85 || v == 21'ha0 || v == 21'h1680 ||
			(v >= 21'h2000 && v <= 21'h200a) || v == 21'h2028 || v == 21'h2029 ||
			v == 21'h202f || v == 21'h205f || v == 21'h3000;
	endfunction

endpackage

// ===== rtl/u8d_decode.sv =====
module u8d_decode #(
	parameter int unsigned OFFSET_WIDTH = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  u8d_pkg::in_item_t                   item,
	input  logic [u8d_pkg::BYTE_LIMIT_W-1:0]    byte_limit,
	input  logic [u8d_pkg::CHAR_LIMIT_W-1:0]    char_limit,
	output logic                                res_valid,
	output u8d_pkg::out_item_t                  res
);
	import u8d_pkg::*;

	localparam int unsigned CNT_W = OFFSET_WIDTH + 1;
	localparam int unsigned XW = (CNT_W > BYTE_LIMIT_W) ? CNT_W : BYTE_LIMIT_W;

	// Per-text state
	logic [SCALAR_W-1:0]     partial_q, partial_d;
	logic [1:0]              due_q, due_d;
	min_class_t              min_q, min_d;
	logic [OFFSET_WIDTH-1:0] cstart_q, cstart_d;
	logic [CNT_W-1:0]        bcount_q, bcount_d;
	logic [CHAR_LIMIT_W-1:0] ccount_q, ccount_d;
	logic                    latched_q, latched_d;

	logic [7:0]          b;
	logic                text_end;
	logic                over_bytes;
	logic                is_cont;
	logic                ascii;
	logic [SCALAR_W-1:0] shifted;
	logic [SCALAR_W-1:0] fin_v;
	min_class_t          fin_min;
	err_code_t           fin_code;
	logic [XW-1:0]       off_x;

	assign b        = item.byte_in;
	assign text_end = item.text_end;
	assign ascii    = (b < 8'h80);
	assign is_cont  = (b[7:6] == 2'b10);
	assign shifted  = {partial_q[SCALAR_W-7:0], b[5:0]};

	// Byte limit or offset overflow
	assign over_bytes = (XW'(bcount_q) >= XW'(byte_limit)) || bcount_q[OFFSET_WIDTH];

	// Character completion checks
	always_comb begin
		fin_v   = ascii && (due_q == 2'd0) ? {13'd0, b} : shifted;
		fin_min = (due_q == 2'd0) ? MIN_NONE : min_q;
		if (fin_v < min_scalar(fin_min) || fin_v > SCALAR_MAX ||
				(fin_v >= SURR_LO && fin_v <= SURR_HI)) begin
			fin_code = ERR_SCALAR;
		end else if (fin_v < 21'd32 && fin_v != 21'd9 && fin_v != 21'd10 &&
				fin_v != 21'd13) begin
			fin_code = ERR_CONTROL;
		end else if (ccount_q >= char_limit) begin
			fin_code = ERR_CHARS;
		end else begin
			fin_code = ERR_OK;
		end
	end

	// Next state and result for the byte in the input stage
	always_comb begin
		logic      finish;
		logic      fail;
		err_code_t code;
		logic [CNT_W-1:0] off;

		partial_d = partial_q;
		due_d     = due_q;
		min_d     = min_q;
		cstart_d  = cstart_q;
		bcount_d  = bcount_q;
		ccount_d  = ccount_q;
		latched_d = latched_q;
		finish    = 1'b0;
		fail      = 1'b0;
		code      = ERR_OK;
		off       = CNT_W'(cstart_q);

		if (latched_q) begin
			// dropped byte
		end else if (over_bytes) begin
			fail = 1'b1;
			code = ERR_BYTES;
			off  = (due_q != 2'd0) ? CNT_W'(cstart_q) : bcount_q;
		end else if (due_q == 2'd0) begin
			cstart_d = bcount_q[OFFSET_WIDTH-1:0];
			bcount_d = bcount_q + 1'b1;
			off      = bcount_q;
			if (ascii) begin
				min_d  = MIN_NONE;
				finish = 1'b1;
			end else if (b >= 8'hc2 && b <= 8'hdf) begin
				partial_d = {16'd0, b[4:0]};
				due_d     = 2'd1;
				min_d     = MIN_2B;
			end else if (b >= 8'he0 && b <= 8'hef) begin
				partial_d = {17'd0, b[3:0]};
				due_d     = 2'd2;
				min_d     = MIN_3B;
			end else if (b >= 8'hf0 && b <= 8'hf4) begin
				partial_d = {18'd0, b[2:0]};
				due_d     = 2'd3;
				min_d     = MIN_4B;
			end else begin
				fail = 1'b1;
				code = ERR_LEAD;
			end
			if (!ascii && !fail && text_end) begin
				fail = 1'b1;
				code = ERR_TRUNC;
			end
		end else begin
			bcount_d = bcount_q + 1'b1;
			if (!is_cont) begin
				fail = 1'b1;
				code = ERR_CONT;
			end else begin
				partial_d = shifted;
				due_d     = due_q - 1'b1;
				if (due_q == 2'd1) begin
					finish = 1'b1;
				end else if (text_end) begin
					fail = 1'b1;
					code = ERR_TRUNC;
				end
			end
		end

		// Character completion
		if (finish) begin
			if (fin_code != ERR_OK) begin
				fail = 1'b1;
				code = fin_code;
			end else begin
				ccount_d  = ccount_q + 1'b1;
				partial_d = '0;
				min_d     = MIN_NONE;
			end
		end

		if (fail && !text_end) begin
			latched_d = 1'b1;
		end

		// End of text clears the per-text state
		if (text_end) begin
			partial_d = '0;
			due_d     = 2'd0;
			min_d     = MIN_NONE;
			cstart_d  = '0;
			bcount_d  = '0;
			ccount_d  = '0;
			latched_d = 1'b0;
		end

		off_x            = XW'(off);
		res_valid        = fail || (finish && fin_code == ERR_OK);
		res.scalar       = fail ? '0 : fin_v;
		res.start_offset = off_x[OUT_OFF_W-1:0];
		res.is_space     = !fail && is_ws(fin_v);
		res.error_code   = fail ? code : ERR_OK;
		res.end_of_run   = text_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			due_q     <= 2'd0;
			min_q     <= MIN_NONE;
			cstart_q  <= '0;
			bcount_q  <= '0;
			ccount_q  <= '0;
			latched_q <= 1'b0;
		end else if (step) begin
			partial_q <= partial_d;
			due_q     <= due_d;
			min_q     <= min_d;
			cstart_q  <= cstart_d;
			bcount_q  <= bcount_d;
			ccount_q  <= ccount_d;
			latched_q <= latched_d;
		end
	end

endmodule

// ===== rtl/utf8_validating_decoder.sv =====
// Path: input register, then result register; the decode logic between them is combinational.
// Throughput: one byte per cycle unless out_ready stalls the result register; the per-text
// state (partial scalar, counters) updates between the two registers as each byte steps.
// Bytes that produce no result (leads, dropped bytes) still advance but give no output.
// Reset: arst_n asynchronous, active low; clears all per-text state and sets
// byte_limit to 32000 and char_limit to 8000.
module utf8_validating_decoder #(
	parameter int unsigned OFFSET_WIDTH = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  u8d_pkg::in_item_t                  in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output u8d_pkg::out_item_t                 out_item,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [u8d_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import u8d_pkg::*;

	logic [BYTE_LIMIT_W-1:0] byte_limit_q;
	logic [CHAR_LIMIT_W-1:0] char_limit_q;

	in_item_t  in_s1;
	logic      in_v_s1;
	out_item_t out_q;
	logic      out_v_q;

	logic      advance;
	logic      step;
	logic      res_valid;
	out_item_t res;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q <= BYTE_LIMIT_RST;
			char_limit_q <= CHAR_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_BYTE_LIMIT) begin
				byte_limit_q <= pwdata[BYTE_LIMIT_W-1:0];
			end else begin
				char_limit_q <= pwdata[CHAR_LIMIT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_CHAR_LIMIT) begin
			prdata = {{(32-CHAR_LIMIT_W){1'b0}}, char_limit_q};
		end else begin
			prdata = {{(32-BYTE_LIMIT_W){1'b0}}, byte_limit_q};
		end
	end

	// Handshake: input stage moves when the result register is free or draining
	assign advance   = !out_v_q || out_ready;
	assign step      = in_v_s1 && advance;
	assign in_ready  = !in_v_s1 || advance;
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (in_ready) begin
			in_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_item;
		end
	end

	u8d_decode #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (in_s1),
		.byte_limit (byte_limit_q),
		.char_limit (char_limit_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= in_v_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

endmodule
